// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

    localparam int unsigned BlockW  = 128;
    localparam int unsigned HalfW   = 64;
    localparam int unsigned NumRnds = 10;
    localparam int unsigned RndW    = 4;

    // Register indexes of the configuration port
    localparam logic [1:0] RegKeyUpper = 2'd0;
    localparam logic [1:0] RegKeyLower = 2'd1;
    localparam logic [1:0] RegDir      = 2'd2;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    localparam logic [7:0] RCON [NumRnds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [BlockW-1:0] sub_bytes(input logic [BlockW-1:0] st,
                                                    input logic inv);
        logic [BlockW-1:0] res;
        res = '0;
        for (int i = 0; i < 16; i++) begin
            res[BlockW-1-8*i -: 8] = inv ? INV_SBOX[st[BlockW-1-8*i -: 8]]
                                         : FWD_SBOX[st[BlockW-1-8*i -: 8]];
        end
        return res;
    endfunction

    // Byte 4c+r holds row r of column c
    function automatic logic [BlockW-1:0] shift_rows(input logic [BlockW-1:0] st,
                                                     input logic inv);
        logic [BlockW-1:0] res;
        int src;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                res[BlockW-1-8*(4*c+r) -: 8] = st[BlockW-1-8*(4*src+r) -: 8];
            end
        end
        return res;
    endfunction

    function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] st,
                                                      input logic inv);
        logic [BlockW-1:0] res;
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m1, m2, m3;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = st[BlockW-1-8*(4*c+j) -: 8];
                a2[j] = xtime(a[j]);
                a4[j] = xtime(a2[j]);
                a8[j] = xtime(a4[j]);
            end
            for (int r = 0; r < 4; r++) begin
                m1 = a[(r+1)&3];
                m2 = a[(r+2)&3];
                m3 = a[(r+3)&3];
                if (inv) begin
                    // 14, 11, 13, 9
                    res[BlockW-1-8*(4*c+r) -: 8] =
                        (a8[r] ^ a4[r] ^ a2[r]) ^
                        (a8[(r+1)&3] ^ a2[(r+1)&3] ^ m1) ^
                        (a8[(r+2)&3] ^ a4[(r+2)&3] ^ m2) ^
                        (a8[(r+3)&3] ^ m3);
                end else begin
                    // 2, 3, 1, 1
                    res[BlockW-1-8*(4*c+r) -: 8] = a2[r] ^ a2[(r+1)&3] ^ m1 ^ m2 ^ m3;
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/aes128_block_cipher.sv =====
`default_nettype none
// AES-128 block cipher, one 128-bit block per transfer, ECB.
// Input channel: i_in_valid / o_in_ready with block halves and a last mark.
// Output channel: o_out_valid / i_out_ready with the result halves and the
// last mark copied from the input.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 key upper, 1 key lower, 2 direction); other indexes are ignored.
// Write config only while idle.
// A key write restarts the key schedule, with o_in_ready low until it ends.
// Reset loads an all-zero key and runs the same schedule.
// The initial key addition happens at the input transfer, then one
// round per cycle in one shared round unit, the last round waiting for a
// free output register. One block at a time.
// A result waiting for the receiver does not block the next input transfer;
// a finished round sequence holds in its last round until the output
// register is free.
module aes128_block_cipher (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [aes_pkg::HalfW-1:0]  i_block_upper,
    input  wire logic [aes_pkg::HalfW-1:0]  i_block_lower,
    input  wire logic                       i_last_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [aes_pkg::HalfW-1:0]  o_out_upper,
    output logic      [aes_pkg::HalfW-1:0]  o_out_lower,
    output logic                            o_last_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [aes_pkg::HalfW-1:0]  i_cfg_data
);
    import aes_pkg::*;

    logic [HalfW-1:0]  r_key_upper, r_key_lower;
    logic              r_dir;
    logic              r_busy;
    logic [RndW-1:0]   r_step;
    logic [BlockW-1:0] r_state;
    logic              r_last;
    logic              r_out_valid;
    logic [BlockW-1:0] r_out_data;
    logic              r_out_last;

    logic              key_start;
    logic              kx_busy;
    logic [RndW-1:0]   rk_idx;
    logic [BlockW-1:0] rk;
    logic [BlockW-1:0] n_state;
    logic [BlockW-1:0] enc_sr, dec_ak;
    logic              in_xfer, fin, final_rnd;

    // Configuration registers
    assign key_start = i_cfg_we && (i_cfg_idx == RegKeyUpper || i_cfg_idx == RegKeyLower);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_dir       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegKeyUpper: r_key_upper <= i_cfg_data;
                RegKeyLower: r_key_lower <= i_cfg_data;
                RegDir:      r_dir       <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    aes_key_exp u_key (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (key_start),
        .i_key    ({r_key_upper, r_key_lower}),
        .i_rd_idx (rk_idx),
        .o_rd_key (rk),
        .o_busy   (kx_busy)
    );

    // Round key select: step 0 is the initial addition
    always_comb begin
        if (!r_busy) begin
            rk_idx = r_dir ? RndW'(NumRnds) : '0;
        end else begin
            rk_idx = r_dir ? RndW'(NumRnds) - r_step : r_step;
        end
    end

    // Shared round unit
    assign final_rnd = (r_step == RndW'(NumRnds));

    always_comb begin
        enc_sr = shift_rows(sub_bytes(r_state, 1'b0), 1'b0);
        dec_ak = sub_bytes(shift_rows(r_state, 1'b1), 1'b1) ^ rk;
        if (r_dir) begin
            n_state = final_rnd ? dec_ak : mix_columns(dec_ak, 1'b1);
        end else begin
            n_state = (final_rnd ? enc_sr : mix_columns(enc_sr, 1'b0)) ^ rk;
        end
    end

    assign o_in_ready = !r_busy && !kx_busy;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign fin        = r_busy && final_rnd && (!r_out_valid || i_out_ready);

    // Round sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
            r_step <= RndW'(1);
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (r_busy && !final_rnd) begin
            r_step <= r_step + RndW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_state <= {i_block_upper, i_block_lower} ^ rk;
            r_last  <= i_last_in;
        end else if (r_busy && !final_rnd) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_data <= n_state;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_upper = r_out_data[BlockW-1:HalfW];
    assign o_out_lower = r_out_data[HalfW-1:0];
    assign o_last_out  = r_out_last;

endmodule
`default_nettype wire

// ===== src/aes_key_exp.sv =====
`default_nettype none
module aes_key_exp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [aes_pkg::BlockW-1:0]  i_key,
    input  wire logic [aes_pkg::RndW-1:0]    i_rd_idx,
    output logic      [aes_pkg::BlockW-1:0]  o_rd_key,
    output logic                             o_busy
);
    import aes_pkg::*;

    logic [BlockW-1:0] r_store [NumRnds+1];
    logic [BlockW-1:0] r_w;
    logic [RndW-1:0]   r_cnt;
    logic              r_busy;
    logic [BlockW-1:0] n_w;
    logic [31:0]       t_word;
    logic [31:0]       w0, w1, w2, w3;

    // One round of the key schedule
    always_comb begin
        t_word = {FWD_SBOX[r_w[23:16]] ^ RCON[r_cnt - RndW'(1)],
                  FWD_SBOX[r_w[15:8]], FWD_SBOX[r_w[7:0]], FWD_SBOX[r_w[31:24]]};
        w0 = r_w[127:96] ^ t_word;
        w1 = r_w[95:64] ^ w0;
        w2 = r_w[63:32] ^ w1;
        w3 = r_w[31:0] ^ w2;
        n_w = {w0, w1, w2, w3};
    end

    // Sequencer: step 0 loads the key, steps 1..10 produce round keys
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + RndW'(1);
            if (r_cnt == RndW'(NumRnds)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            if (r_cnt == '0) begin
                r_w            <= i_key;
                r_store[r_cnt] <= i_key;
            end else begin
                r_w            <= n_w;
                r_store[r_cnt] <= n_w;
            end
        end
    end

    assign o_rd_key = r_store[i_rd_idx];
    assign o_busy   = r_busy;

endmodule
`default_nettype wire

// ===== src/aes_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module aes_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [aes_pkg::HalfW-1:0]  o_out_upper,
    input wire logic [aes_pkg::HalfW-1:0]  o_out_lower,
    input wire logic                       o_last_out,
    input wire logic                       i_cfg_we,
    input wire logic [1:0]                 i_cfg_idx
);
    import aes_pkg::*;

    // A block in flight keeps the input closed
    `ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready)
    // A key write starts the schedule, input closed meanwhile
    `ASSERT_NEXT(a_key_sched, i_cfg_we && (i_cfg_idx == RegKeyUpper || i_cfg_idx == RegKeyLower), !o_in_ready)
    // A new result only shows up after a block was being worked on
    `ASSERT_IMPL(a_out_from_work, $rose(o_out_valid), $past(!o_in_ready))
    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_upper) && $stable(o_out_lower) && $stable(o_last_out))

endmodule

bind aes128_block_cipher aes_checker u_chk (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
        logic        last;
    } block_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_block_upper;
    logic [63:0] i_block_lower;
    logic        i_last_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_upper;
    logic [63:0] o_out_lower;
    logic        o_last_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes128_block_cipher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_block_upper(i_block_upper), .i_block_lower(i_block_lower),
        .i_last_in(i_last_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_upper(o_out_upper), .o_out_lower(o_out_lower),
        .o_last_out(o_last_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int unsigned WatchdogLimit = 20000;
    localparam int unsigned IdleWait      = 40;

    // Cipher state kept by the testbench
    logic [63:0]  key_hi, key_lo;
    logic         decrypt_mode;
    logic [127:0] round_keys [11];

    block_t pending_blocks [$];
    block_t expected_blocks [$];
    int     error_count;
    int     stall_cycles;
    int     gap_left;
    int     out_hold_left;
    bit     hold_sender;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] gf_double(logic [7:0] b);
        return (b[7]) ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gf_times(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) acc ^= x;
            x = gf_double(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] byte_at(logic [127:0] s, int i);
        return s[127-8*i -: 8];
    endfunction

    // Key schedule from the current key registers
    function automatic void build_schedule();
        logic [7:0] w [16];
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [127:0] k;
        k = {key_hi, key_lo};
        round_keys[0] = k;
        for (int i = 0; i < 16; i++) w[i] = byte_at(k, i);
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            t[0] = FWD_SBOX[w[13]] ^ rc;
            t[1] = FWD_SBOX[w[14]];
            t[2] = FWD_SBOX[w[15]];
            t[3] = FWD_SBOX[w[12]];
            for (int j = 0; j < 4; j++) w[j] ^= t[j];
            for (int j = 4; j < 16; j++) w[j] ^= w[j-4];
            for (int j = 0; j < 16; j++) k[127-8*j -: 8] = w[j];
            round_keys[r] = k;
            rc = gf_double(rc);
        end
    endfunction

    function automatic logic [127:0] cipher_block(logic [127:0] din, logic inv);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [127:0] res;
        int rk, src;
        for (int i = 0; i < 16; i++) s[i] = byte_at(din, i);
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
        rk = inv ? 10 : 0;
        for (int i = 0; i < 16; i++) s[i] ^= byte_at(round_keys[rk], i);
        for (int n = 1; n <= 10; n++) begin
            rk = inv ? 10 - n : n;
            // substitute and shift rows (order commutes)
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                    t[4*c+r] = inv ? INV_SBOX[s[4*src+r]] : FWD_SBOX[s[4*src+r]];
                end
            end
            s = t;
            // forward: mix then add key; inverse: add key then mix
            if (inv) for (int i = 0; i < 16; i++) s[i] ^= byte_at(round_keys[rk], i);
            if (n != 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                    for (int r = 0; r < 4; r++) begin
                        s[4*c+r] = 8'h00;
                        for (int j = 0; j < 4; j++)
                            s[4*c+r] ^= gf_times(a[(r+j)&3], m[j]);
                    end
                end
            end
            if (!inv) for (int i = 0; i < 16; i++) s[i] ^= byte_at(round_keys[rk], i);
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Driver: one transfer per handshake, random gaps between blocks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_block_upper <= '0;
            i_block_lower <= '0;
            i_last_in     <= 1'b0;
            gap_left      <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold
        end else begin
            block_t nxt;
            logic [127:0] ct;
            if (i_in_valid) begin
                ct = cipher_block({i_block_upper, i_block_lower}, decrypt_mode);
                expected_blocks.push_back('{ct[127:64], ct[63:0], i_last_in});
            end
            if (gap_left > 0 || hold_sender || pending_blocks.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                nxt = pending_blocks.pop_front();
                i_in_valid    <= 1'b1;
                i_block_upper <= nxt.upper;
                i_block_lower <= nxt.lower;
                i_last_in     <= nxt.last;
                gap_left      <= pick_gap();
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        block_t want;
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            out_hold_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected out_upper", o_out_upper, 64'h0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (o_out_upper !== want.upper)
                        report_mismatch("out_upper", o_out_upper, want.upper);
                    if (o_out_lower !== want.lower)
                        report_mismatch("out_lower", o_out_lower, want.lower);
                    if (o_last_out !== want.last)
                        report_mismatch("last_out", 64'(o_last_out), 64'(want.last));
                end
            end
            if (out_hold_left > 0) begin
                i_out_ready   <= 1'b0;
                out_hold_left <= out_hold_left - 1;
            end else begin
                i_out_ready   <= 1'b1;
                out_hold_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (pending_blocks.size() == 0 && !i_in_valid && expected_blocks.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            RegKeyUpper: begin key_hi = val; build_schedule(); end
            RegKeyLower: begin key_lo = val; build_schedule(); end
            RegDir:      decrypt_mode = val[0];
            default: ;
        endcase
    endtask

    // Let everything drain, then settle for the block latency
    task automatic wait_idle();
        while (pending_blocks.size() != 0 || i_in_valid || expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (IdleWait) @(posedge i_clk);
    endtask

    task automatic add_block(logic [63:0] u, logic [63:0] l, logic last);
        pending_blocks.push_back('{u, l, last});
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0:       add_block($urandom_range(0, 1) ? '1 : '0, rand64(),
                                   1'($urandom_range(0, 1)));
                1:       add_block(rand64(), 64'(1) << $urandom_range(0, 63),
                                   1'($urandom_range(0, 1)));
                default: add_block(rand64(), rand64(), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial begin
        logic [1:0] bad_idx;
        hold_sender   = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = RegKeyUpper;
        i_cfg_data    = '0;
        key_hi        = '0;
        key_lo        = '0;
        decrypt_mode  = 1'b0;
        build_schedule();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero key, field extremes, both directions
        add_block('0, '0, 1'b0);
        add_block('1, '1, 1'b1);
        add_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        add_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
        wait_idle();
        // FIPS-197 example key
        write_reg(RegKeyUpper, 64'h0001020304050607);
        write_reg(RegKeyLower, 64'h08090a0b0c0d0e0f);
        add_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        add_block('1, '0, 1'b1);
        wait_idle();
        write_reg(RegDir, 64'h1);
        add_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        add_block('0, '1, 1'b0);
        wait_idle();
        // Unknown index ignored; bits above the direction width ignored
        bad_idx = 2'd3;
        write_reg(bad_idx, '1);
        write_reg(RegDir, 64'hfffffffffffffffe);
        add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        wait_idle();
        // Single key half update with the other half kept; all-ones key
        write_reg(RegKeyUpper, '1);
        add_block('0, '0, 1'b1);
        wait_idle();
        write_reg(RegKeyLower, '1);
        write_reg(RegDir, 64'h1);
        add_block('1, '1, 1'b0);
        add_block('0, '0, 1'b1);
        wait_idle();

        // Random phases, fresh key and direction each time
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(RegKeyUpper, rand64());
            write_reg(RegKeyLower, rand64());
            write_reg(RegDir, 64'($urandom_range(0, 1)));
            random_phase(100);
            if (ph == 4) begin
                // sender stops until every result is back
                while (pending_blocks.size() > 50) @(posedge i_clk);
                hold_sender = 1'b1;
                while (i_in_valid || expected_blocks.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
